>>> rtl/grs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants of the gradient ramp sampler
// Table geometry, field widths, request codes and the sequencer state type.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int MAX_STOPS  = 15;
    localparam int ADDR_W     = $clog2(MAX_STOPS);
    localparam int MEM_DEPTH  = 2 ** ADDR_W;

    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 4;
    localparam int RATIO_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int COLOR_W    = CHAN_W * NUM_CHAN;

    localparam int FRAC_SHIFT = 16;
    localparam int DIV_STEPS  = FRAC_SHIFT + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int REM_W      = RATIO_W + 1;
    localparam int DIFF_W     = CHAN_W + 1;
    localparam int ACC_W      = DIFF_W + DIV_STEPS;
    localparam int STEP_W     = ACC_W - FRAC_SHIFT;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/gradient_ramp_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_ramp_sampler: multi-stop color gradient lookup
// Write beat: taken while idle, ready again on the next cycle, no result.
// Sample beat: scans the stops in order (1 to stop_count of them), then runs a
// bit-serial division and a finish step when it interpolates; the result waits
// until the output register is free, and the next beat is taken once it moves.
// Reset: sequencer idle, no result pending, stop_count = 1; table unchanged.
// ----------------------------------------------------------------------------
module gradient_ramp_sampler (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [grs_pkg::COUNT_W-1:0]      cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [grs_pkg::INDEX_W-1:0]      s_stop_index,
    input  logic [grs_pkg::RATIO_W-1:0]      s_stop_ratio,
    input  logic [grs_pkg::COLOR_W-1:0]      s_stop_color,
    input  logic [grs_pkg::RATIO_W-1:0]      s_sample_ratio,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [grs_pkg::COLOR_W-1:0]      m_sample_color
);

    grs_pkg::state_t state_reg;
    grs_pkg::state_t state_next;

    logic [grs_pkg::COUNT_W-1:0]   stop_count_reg;
    logic                          m_valid_reg;
    logic [grs_pkg::COLOR_W-1:0]   m_color_reg;

    logic [grs_pkg::RATIO_W-1:0]   ratio_mem [grs_pkg::MEM_DEPTH];
    logic [grs_pkg::COLOR_W-1:0]   color_mem [grs_pkg::MEM_DEPTH];
    logic [grs_pkg::RATIO_W-1:0]   rd_ratio_reg;
    logic [grs_pkg::COLOR_W-1:0]   rd_color_reg;
    logic [grs_pkg::ADDR_W-1:0]    rd_addr;

    logic [grs_pkg::RATIO_W-1:0]   pos_reg;
    logic [grs_pkg::ADDR_W-1:0]    idx_reg;
    logic [grs_pkg::ADDR_W-1:0]    last_idx_reg;
    logic [grs_pkg::ADDR_W-1:0]    last_idx_calc;
    logic [grs_pkg::RATIO_W-1:0]   prev_ratio_reg;
    logic [grs_pkg::COLOR_W-1:0]   prev_color_reg;
    logic [grs_pkg::COLOR_W-1:0]   result_reg;

    logic [grs_pkg::RATIO_W-1:0]   span_reg;
    logic [grs_pkg::REM_W-1:0]     rem_reg;
    logic [grs_pkg::REM_W-1:0]     rem_sub;
    logic                          div_bit;
    logic [grs_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic signed [grs_pkg::DIFF_W-1:0] diff_reg [grs_pkg::NUM_CHAN];
    logic signed [grs_pkg::ACC_W-1:0]  acc_reg  [grs_pkg::NUM_CHAN];
    logic [grs_pkg::COLOR_W-1:0]       lerp_color;

    logic in_beat;
    logic wr_beat;
    logic smp_beat;
    logic out_free;

    logic scan_first;
    logic scan_below;
    logic scan_hit;
    logic scan_interp;
    logic scan_last;

    int count_eff;

    assign in_beat  = s_valid && s_ready;
    assign wr_beat  = in_beat && (s_req_type == grs_pkg::REQ_WRITE);
    assign smp_beat = in_beat && (s_req_type == grs_pkg::REQ_SAMPLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        count_eff = int'(stop_count_reg);
        if (count_eff < 1) begin
            count_eff = 1;
        end
        if (count_eff > grs_pkg::MAX_STOPS) begin
            count_eff = grs_pkg::MAX_STOPS;
        end
        last_idx_calc = grs_pkg::ADDR_W'(count_eff - 1);
    end

    assign scan_first  = (idx_reg == '0);
    assign scan_below  = scan_first && (pos_reg < rd_ratio_reg);
    assign scan_hit    = !scan_first && (rd_ratio_reg >= pos_reg);
    assign scan_interp = scan_hit && (rd_ratio_reg > prev_ratio_reg)
                         && (pos_reg >= prev_ratio_reg);
    assign scan_last   = (idx_reg == last_idx_reg);

    assign div_bit = (rem_reg >= {1'b0, span_reg});
    assign rem_sub = div_bit ? (rem_reg - {1'b0, span_reg}) : rem_reg;

    always_comb begin
        for (int k = 0; k < grs_pkg::NUM_CHAN; k++) begin
            lerp_color[k*grs_pkg::CHAN_W +: grs_pkg::CHAN_W] =
                grs_pkg::CHAN_W'(
                    $signed({{(grs_pkg::STEP_W-grs_pkg::CHAN_W){1'b0}},
                             prev_color_reg[k*grs_pkg::CHAN_W +: grs_pkg::CHAN_W]})
                    + acc_reg[k][grs_pkg::ACC_W-1:grs_pkg::FRAC_SHIFT]);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grs_pkg::ST_IDLE: begin
                if (smp_beat) begin
                    state_next = grs_pkg::ST_SCAN;
                end
            end
            grs_pkg::ST_SCAN: begin
                if (scan_below) begin
                    state_next = grs_pkg::ST_DONE;
                end else if (scan_hit) begin
                    state_next = scan_interp ? grs_pkg::ST_DIV : grs_pkg::ST_DONE;
                end else if (scan_last) begin
                    state_next = grs_pkg::ST_DONE;
                end
            end
            grs_pkg::ST_DIV: begin
                if (div_cnt_reg == grs_pkg::DIV_CNT_W'(grs_pkg::DIV_STEPS - 1)) begin
                    state_next = grs_pkg::ST_FIN;
                end
            end
            grs_pkg::ST_FIN: begin
                state_next = grs_pkg::ST_DONE;
            end
            grs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = grs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b1;
        rd_addr   = idx_reg + 1'b1;
        unique case (state_reg)
            grs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = '0;
            end
            grs_pkg::ST_SCAN,
            grs_pkg::ST_DIV,
            grs_pkg::ST_FIN,
            grs_pkg::ST_DONE: begin
                s_ready = 1'b0;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_color = m_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= grs_pkg::ST_IDLE;
            stop_count_reg <= grs_pkg::COUNT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                stop_count_reg <= cfg_data;
            end
            if (state_reg == grs_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == grs_pkg::ST_DONE && out_free) begin
            m_color_reg <= result_reg;
        end
    end

    // stop table
    always_ff @(posedge aclk) begin
        if (wr_beat && (32'(s_stop_index) < grs_pkg::MAX_STOPS)) begin
            ratio_mem[grs_pkg::ADDR_W'(s_stop_index)] <= s_stop_ratio;
            color_mem[grs_pkg::ADDR_W'(s_stop_index)] <= s_stop_color;
        end
        rd_ratio_reg <= ratio_mem[rd_addr];
        rd_color_reg <= color_mem[rd_addr];
    end

    // scan, divide and accumulate
    always_ff @(posedge aclk) begin
        case (state_reg)
            grs_pkg::ST_IDLE: begin
                if (smp_beat) begin
                    pos_reg      <= s_sample_ratio;
                    last_idx_reg <= last_idx_calc;
                    idx_reg      <= '0;
                end
            end
            grs_pkg::ST_SCAN: begin
                if (scan_below) begin
                    result_reg <= rd_color_reg;
                end else if (scan_hit) begin
                    result_reg  <= prev_color_reg;
                    span_reg    <= rd_ratio_reg - prev_ratio_reg;
                    rem_reg     <= {1'b0, pos_reg - prev_ratio_reg};
                    div_cnt_reg <= '0;
                    for (int k = 0; k < grs_pkg::NUM_CHAN; k++) begin
                        diff_reg[k] <= $signed({1'b0,
                            rd_color_reg[k*grs_pkg::CHAN_W +: grs_pkg::CHAN_W]})
                            - $signed({1'b0,
                            prev_color_reg[k*grs_pkg::CHAN_W +: grs_pkg::CHAN_W]});
                        acc_reg[k]  <= '0;
                    end
                end else begin
                    prev_ratio_reg <= rd_ratio_reg;
                    prev_color_reg <= rd_color_reg;
                    result_reg     <= rd_color_reg;
                    idx_reg        <= idx_reg + 1'b1;
                end
            end
            grs_pkg::ST_DIV: begin
                rem_reg     <= {rem_sub[grs_pkg::REM_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 1'b1;
                for (int k = 0; k < grs_pkg::NUM_CHAN; k++) begin
                    acc_reg[k] <= (acc_reg[k] <<< 1)
                                  + (div_bit ? grs_pkg::ACC_W'(diff_reg[k])
                                             : grs_pkg::ACC_W'(0));
                end
            end
            grs_pkg::ST_FIN: begin
                result_reg <= lerp_color;
            end
            default: begin
            end
        endcase
    end

    a_sample_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        smp_beat |=> state_reg == grs_pkg::ST_SCAN)
        else $error("sample beat did not start the stop scan");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_beat |=> state_reg == grs_pkg::ST_IDLE)
        else $error("write beat left the sequencer busy");

    a_div_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == grs_pkg::ST_DIV
            |-> div_cnt_reg < grs_pkg::DIV_CNT_W'(grs_pkg::DIV_STEPS))
        else $error("divider ran past its last quotient bit");

    a_done_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == grs_pkg::ST_DONE && out_free
            |=> m_valid_reg && state_reg == grs_pkg::ST_IDLE)
        else $error("finished result was not moved to the output register");

endmodule
